// File: hw/rtl/q16m_pkg.sv
// package for the q16.16 math unit: op and error codes, widths, constants
// no dependencies
`default_nettype none
package q16m_pkg;
    localparam int DataW    = 32;
    localparam int FracW    = 16;
    localparam int OpW      = 3;
    localparam int ErrW     = 3;
    localparam int ThrW     = 16;
    localparam int MaxIterDefault = 32;
    localparam logic [ThrW-1:0] ThrReset = 16'd6;

    typedef enum logic [OpW-1:0] {
        OP_MUL  = 3'd0,
        OP_DIV  = 3'd1,
        OP_FLT  = 3'd2,
        OP_ABS  = 3'd3,
        OP_SQRT = 3'd4,
        OP_CBRT = 3'd5
    } t_op;

    typedef enum logic [ErrW-1:0] {
        ERR_OK     = 3'd0,
        ERR_DIV0   = 3'd1,
        ERR_DIVOVF = 3'd2,
        ERR_FLT    = 3'd3,
        ERR_NOCONV = 3'd4
    } t_err;
endpackage
`default_nettype wire

// File: hw/rtl/q16m_div.sv
// radix-2 restoring divider: (a * 65536) / b, signed, truncating
// flags divide by zero and quotient overflow; uses q16m_pkg
`default_nettype none
module q16m_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [q16m_pkg::DataW-1:0] i_num,
    input  wire logic signed [q16m_pkg::DataW-1:0] i_den,
    output logic                              o_done,
    output logic signed [q16m_pkg::DataW-1:0] o_quot,
    output q16m_pkg::t_err                    o_err
);
    localparam int NW = q16m_pkg::DataW + q16m_pkg::FracW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_num, n_num;
    logic [NW-1:0]  r_quo, n_quo;
    logic [q16m_pkg::DataW:0] r_rem, n_rem;
    logic [q16m_pkg::DataW-1:0] r_den, n_den;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy, r_neg, n_neg;
    logic [q16m_pkg::DataW:0] w_sh, w_sub;
    logic [NW:0]    w_sq;

    always_comb begin
        n_num = r_num; n_quo = r_quo; n_rem = r_rem; n_den = r_den;
        n_cnt = r_cnt; n_busy = r_busy; n_neg = r_neg;
        o_done = 1'b0; o_quot = '0; o_err = q16m_pkg::ERR_OK;
        w_sh  = {r_rem[q16m_pkg::DataW-1:0], r_num[NW-1]};
        w_sub = w_sh - {1'b0, r_den};
        w_sq  = r_neg ? ({1'b0, ~r_quo} + 1'b1) : {1'b0, r_quo};
        if (i_start) begin
            n_num = {(i_num[q16m_pkg::DataW-1] ? -i_num : i_num), {q16m_pkg::FracW{1'b0}}};
            n_den = i_den[q16m_pkg::DataW-1] ? -i_den : i_den;
            n_neg = i_num[q16m_pkg::DataW-1] ^ i_den[q16m_pkg::DataW-1];
            n_rem = '0; n_quo = '0;
            n_cnt = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_den == '0) begin
                n_busy = 1'b0; o_done = 1'b1; o_err = q16m_pkg::ERR_DIV0;
            end else if (r_cnt != '0) begin
                n_num = {r_num[NW-2:0], 1'b0};
                if (!w_sub[q16m_pkg::DataW]) begin
                    n_rem = w_sub; n_quo = {r_quo[NW-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;  n_quo = {r_quo[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_busy = 1'b0; o_done = 1'b1;
                if (r_neg ? (r_quo > (NW'(1) << (q16m_pkg::DataW-1)))
                          : (r_quo >= (NW'(1) << (q16m_pkg::DataW-1))))
                    o_err = q16m_pkg::ERR_DIVOVF;
                else
                    o_quot = w_sq[q16m_pkg::DataW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_num <= n_num; r_quo <= n_quo; r_rem <= n_rem; r_den <= n_den;
        r_cnt <= n_cnt; r_neg <= n_neg;
    end
endmodule
`default_nettype wire

// File: hw/rtl/q16_fixed_point_math_unit.sv
// top level of the q16.16 math unit: sequencer around one shared divider
// depends on q16m_pkg and q16m_div
//
// channel   direction  handshake                 payload
// command   in         i_start & ~o_busy         i_op, i_operand_a, i_operand_b
// result    out        o_done (one cycle)        o_result, o_error
// config    in         i_cfg_we                  i_cfg_wdata
//
// from accept to o_done: multiply passes S_MUL, S_SQ and S_FIN; abs, from-float and
// spare codes go straight to S_FIN; divide waits in S_DIVW for the shared divider
// (48 quotient bits, one per cycle); roots run newton steps through the divider,
// S_DIFF, S_DT and S_STEP, up to MAX_ITER steps; o_busy stays high through the o_done cycle
// synchronous active-low reset; results cannot be stalled
`default_nettype none
module q16_fixed_point_math_unit #(
    parameter int MAX_ITER = q16m_pkg::MaxIterDefault
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [q16m_pkg::OpW-1:0]          i_op,
    input  wire logic signed [q16m_pkg::DataW-1:0] i_operand_a,
    input  wire logic signed [q16m_pkg::DataW-1:0] i_operand_b,
    input  wire logic                              i_cfg_we,
    input  wire logic [q16m_pkg::ThrW-1:0]         i_cfg_wdata,
    output logic                                   o_done,
    output logic signed [q16m_pkg::DataW-1:0]      o_result,
    output logic [q16m_pkg::ErrW-1:0]              o_error
);
    localparam int W  = q16m_pkg::DataW;
    localparam int IW = $clog2(MAX_ITER + 1);
    localparam logic [W-1:0] Recip3 = 32'haaaaaaab;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_SQ   = 9'b000000100,
        S_DIVW = 9'b000001000,
        S_STEP = 9'b000010000,
        S_FIN  = 9'b000100000,
        S_DIVS = 9'b001000000,
        S_DIFF = 9'b010000000,
        S_DT   = 9'b100000000
    } t_state;

    t_state r_st, n_st;
    logic [q16m_pkg::OpW-1:0] r_op;
    logic signed [W-1:0] r_a, r_b, r_t, n_t;
    logic signed [2*W-1:0] r_prod;
    logic signed [W-1:0] r_res, n_res;
    q16m_pkg::t_err r_err, n_err;
    logic [IW-1:0] r_it, n_it;
    logic [q16m_pkg::ThrW-1:0] r_thr;
    logic r_done, n_done;
    logic r_mul, n_mul;
    logic signed [W-1:0] r_q;
    logic [W-1:0] r_dmag;
    logic r_dneg;
    logic w_acc;

    logic d_start, d_done;
    logic signed [W-1:0] d_num, d_den, d_q;
    q16m_pkg::t_err d_err;

    assign w_acc = i_start && !r_done;

    q16m_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quot(d_q), .o_err(d_err)
    );

    // shared multiplier: product, square of t, or |q - t| by the reciprocal of 3
    logic signed [2*W-1:0] w_ma, w_mb, w_prod_adj;
    logic signed [W-1:0] w_mq;
    always_comb begin
        if (r_st == S_DT) begin
            w_ma = {{W{1'b0}}, r_dmag};
            w_mb = {{W{1'b0}}, Recip3};
        end else if (r_mul) begin
            w_ma = {{W{r_a[W-1]}}, r_a};
            w_mb = {{W{r_b[W-1]}}, r_b};
        end else begin
            w_ma = {{W{r_t[W-1]}}, r_t};
            w_mb = {{W{r_t[W-1]}}, r_t};
        end
    end
    assign w_prod_adj = r_prod + (r_prod[2*W-1] ? 64'sd65535 : 64'sd0);
    assign w_mq = w_prod_adj[q16m_pkg::FracW +: W];

    // from float
    logic [7:0] w_ex;
    logic [W:0] w_man, w_mag;
    logic signed [9:0] w_sh;
    logic w_frng;
    always_comb begin
        w_ex  = r_a[30:23];
        w_man = {10'd1, r_a[22:0]};
        w_sh  = $signed({2'b00, w_ex}) - 10'sd134;
        w_mag = '0;
        w_frng = 1'b0;
        if (w_ex == 8'hff || w_sh > 10'sd8) w_frng = 1'b1;
        else if (w_sh >= 0) w_mag = w_man << w_sh[3:0];
        else if (w_sh > -10'sd32) w_mag = w_man >> 6'(-w_sh);
        if (w_mag > {1'b0, 1'b1, {(W-1){1'b0}}}) w_frng = 1'b1;
    end

    // newton step: |q - t| registered, then halved or divided by 3
    logic signed [W:0] w_diff, w_ndiff;
    logic [W-1:0] w_dmag, w_dq;
    logic [W:0] w_dx;
    logic signed [W:0] w_dt, w_nt;
    always_comb begin
        w_diff  = (W+1)'(r_q) - (W+1)'(r_t);
        w_ndiff = -w_diff;
        w_dmag  = w_diff[W] ? w_ndiff[W-1:0] : w_diff[W-1:0];
        w_dq    = (r_op == q16m_pkg::OP_CBRT) ? {1'b0, r_prod[2*W-1:W+1]}
                                              : {1'b0, r_dmag[W-1:1]};
        w_dx    = {1'b0, w_dq};
        w_dt    = r_dneg ? -w_dx : w_dx;
        w_nt    = (W+1)'(r_t) + w_dt;
    end

    always_comb begin
        n_st = r_st; n_t = r_t; n_res = r_res; n_err = r_err; n_it = r_it;
        n_done = 1'b0; n_mul = r_mul;
        d_start = 1'b0; d_num = r_a; d_den = r_b;
        unique case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_err = q16m_pkg::ERR_OK; n_res = '0;
                    n_t = W'(2) << q16m_pkg::FracW; n_it = '0;
                    n_mul = (i_op == q16m_pkg::OP_MUL);
                    priority case (i_op)
                        q16m_pkg::OP_MUL: n_st = S_MUL;
                        q16m_pkg::OP_DIV: begin
                            d_start = 1'b1; d_num = i_operand_a; d_den = i_operand_b;
                            n_st = S_DIVW;
                        end
                        q16m_pkg::OP_SQRT: begin
                            d_start = 1'b1; d_num = i_operand_a;
                            d_den = W'(2) << q16m_pkg::FracW; n_st = S_DIVS;
                        end
                        q16m_pkg::OP_CBRT: n_st = S_MUL;
                        default: n_st = S_FIN;
                    endcase
                end
            end
            S_MUL: n_st = S_SQ;
            S_SQ: begin
                if (r_mul) begin
                    n_res = w_mq; n_st = S_FIN;
                end else begin
                    d_start = 1'b1; d_num = r_a; d_den = w_mq; n_st = S_DIVS;
                end
            end
            S_DIVW: begin
                if (d_done) begin
                    n_err = d_err; n_res = d_q; n_st = S_FIN;
                end
            end
            S_DIVS: begin
                if (d_done) begin
                    if (d_err != q16m_pkg::ERR_OK) begin
                        n_err = d_err; n_st = S_FIN;
                    end else n_st = S_DIFF;
                end
            end
            S_DIFF: n_st = S_DT;
            S_DT: n_st = S_STEP;
            S_STEP: begin
                n_t = w_nt[W-1:0];
                n_it = r_it + 1'b1;
                if (w_dq <= W'(r_thr)) begin
                    n_res = w_nt[W-1:0]; n_st = S_FIN;
                end else if (r_it + 1'b1 >= IW'(MAX_ITER)) begin
                    n_err = q16m_pkg::ERR_NOCONV; n_st = S_FIN;
                end else if (r_op == q16m_pkg::OP_CBRT) begin
                    n_st = S_MUL;
                end else begin
                    d_start = 1'b1; d_num = r_a; d_den = w_nt[W-1:0]; n_st = S_DIVS;
                end
            end
            S_FIN: begin
                priority case (r_op)
                    q16m_pkg::OP_FLT: begin
                        if (r_a[30:23] == 8'd0) n_res = '0;
                        else if (w_frng) n_err = q16m_pkg::ERR_FLT;
                        else n_res = r_a[W-1] ? -w_mag[W-1:0] : w_mag[W-1:0];
                    end
                    q16m_pkg::OP_ABS: n_res = r_a[W-1] ? -r_a : r_a;
                    default: ;
                endcase
                n_done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_done <= 1'b0; r_thr <= q16m_pkg::ThrReset;
        end else begin
            r_st <= n_st; r_done <= n_done;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
        end
        if (r_st == S_IDLE && w_acc) begin
            r_op <= i_op; r_a <= i_operand_a; r_b <= i_operand_b;
        end
        if (d_done) r_q <= d_q;
        r_prod <= w_ma * w_mb;
        r_dmag <= w_dmag; r_dneg <= w_diff[W];
        r_t <= n_t; r_res <= n_res; r_err <= n_err; r_it <= n_it; r_mul <= n_mul;
    end

    assign o_busy   = (r_st != S_IDLE) || r_done;
    assign o_done   = r_done;
    assign o_result = (r_err == q16m_pkg::ERR_OK) ? r_res : '0;
    assign o_error  = r_err;
endmodule
`default_nettype wire

// File: hw/rtl/q16m_chk.sv
// port-level checker for the q16.16 math unit, bound to the top level
// depends on q16m_pkg
`default_nettype none
module q16m_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire logic [31:0] o_result,
    input wire logic [2:0] o_error
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_error != q16m_pkg::ERR_OK |-> o_result == 32'd0)
        else $error("nonzero result on error");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_error <= q16m_pkg::ERR_NOCONV) else $error("bad error code");
    a_busy_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("not busy after accept");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
endmodule

bind q16_fixed_point_math_unit q16m_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_result(o_result), .o_error(o_error)
);
`default_nettype wire
